/* design/erm_pkg.sv */
// Shared types, constants and the rounded Q30 product for the Euler rotation matrix.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package erm_pkg;

  localparam logic signed [37:0] HALF_PI      = 38'sh1_921F_B544;
  localparam logic signed [37:0] HALF_PI_HALF = 38'sh0_C90F_DAA2;
  localparam logic [30:0]        Q30_ONE      = 31'h4000_0000;

  localparam int SIN_STEPS = 5;
  localparam int COS_STEPS = 6;

  // ceil(2^(30+l)/d), l = ceil(log2 d): exact floor division for 30-bit dividends
  localparam logic [31:0] SIN_MAGIC [SIN_STEPS] = '{
    32'(((64'd1 << 37) + 64'd109) / 64'd110),
    32'(((64'd1 << 37) + 64'd71) / 64'd72),
    32'(((64'd1 << 36) + 64'd41) / 64'd42),
    32'(((64'd1 << 35) + 64'd19) / 64'd20),
    32'(((64'd1 << 33) + 64'd5) / 64'd6)
  };
  localparam int SIN_SHIFT [SIN_STEPS] = '{37, 37, 36, 35, 33};

  localparam logic [31:0] COS_MAGIC [COS_STEPS] = '{
    32'(((64'd1 << 38) + 64'd131) / 64'd132),
    32'(((64'd1 << 37) + 64'd89) / 64'd90),
    32'(((64'd1 << 36) + 64'd55) / 64'd56),
    32'(((64'd1 << 35) + 64'd29) / 64'd30),
    32'(((64'd1 << 34) + 64'd11) / 64'd12),
    32'(((64'd1 << 31) + 64'd1) / 64'd2)
  };
  localparam int COS_SHIFT [COS_STEPS] = '{38, 37, 36, 35, 34, 31};

  localparam int RED_LAT  = 4;
  localparam int POLY_LAT = 14;
  localparam int MAT_LAT  = 4;
  localparam int PIPE_LAT = RED_LAT + POLY_LAT + MAT_LAT;

  typedef struct packed {
    logic [29:0] m;
    logic        neg;
    logic [1:0]  q;
  } erm_red_t;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } erm_sc_t;

  function automatic logic signed [37:0] hp_times(input int k);
    return 38'(k) * HALF_PI;
  endfunction

  // magnitude product rounded half up, sign applied after
  function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic [30:0] ma;
    logic [30:0] mb;
    logic [61:0] p;
    logic [31:0] r;
    ma = a[31] ? 31'(-a) : a[30:0];
    mb = b[31] ? 31'(-b) : b[30:0];
    p  = 62'(ma) * 62'(mb);
    r  = 32'((p + (62'd1 << 29)) >> 30);
    return (a[31] ^ b[31]) ? -$signed(r) : $signed(r);
  endfunction

endpackage

`default_nettype wire

/* design/euler_rotation_matrix.sv */
// Throughput: one word per cycle unless stalled; 22 register stages (reduction 4, series 14, products 4).
// A stall holds the whole pipeline; a one-word skid behind the output register keeps
// s_tready registered. rst clears the valid bits, output valid and skid; data regs
// are not reset. Top level; uses erm_pkg, erm_reduce, erm_poly, erm_matrix.
`timescale 1ns / 1ps
`default_nettype none

module euler_rotation_matrix #(
  parameter int ANGLE_WIDTH = 16,
  parameter int ENTRY_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // angle_x, angle_y, angle_z
  input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [((9*ENTRY_WIDTH+7)/8)*8-1:0] m_tdata
);
  import erm_pkg::*;

  localparam int RES_W = 9 * ENTRY_WIDTH;
  localparam int OUT_W = ((9*ENTRY_WIDTH+7)/8)*8;

  logic              en;
  logic [PIPE_LAT-1:0] vld;
  logic              skid_v;
  logic [RES_W-1:0]  skid_d;
  logic [RES_W-1:0]  out_d;
  logic [RES_W-1:0]  res;
  logic              out_load;
  logic              last_v;
  erm_red_t          red [3];
  erm_sc_t           sc  [3];

  assign en       = !skid_v;
  assign s_tready = en;
  assign out_load = !m_tvalid || m_tready;
  assign last_v   = vld[PIPE_LAT-1];
  assign m_tdata  = OUT_W'(out_d);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    erm_reduce #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_reduce (
      .clk   (clk),
      .en    (en),
      .angle (s_tdata[a*ANGLE_WIDTH +: ANGLE_WIDTH]),
      .red   (red[a])
    );
    erm_poly u_poly (
      .clk (clk),
      .en  (en),
      .red (red[a]),
      .sc  (sc[a])
    );
  end

  erm_matrix #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_matrix (
    .clk (clk),
    .en  (en),
    .ax  (sc[0]),
    .ay  (sc[1]),
    .az  (sc[2]),
    .ent (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
      skid_v   <= 1'b0;
    end else begin
      if (en) vld <= {vld[PIPE_LAT-2:0], s_tvalid};
      if (out_load) begin
        if (skid_v) begin
          m_tvalid <= 1'b1;
          skid_v   <= 1'b0;
        end else begin
          m_tvalid <= en && last_v;
        end
      end else if (en && last_v) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_d <= skid_v ? skid_d : res;
    if (en) skid_d <= res;
  end

`ifndef SYNTHESIS
  a_skid_behind_valid: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> m_tvalid) else $error("skid holds a word while output is empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(m_tvalid && !m_tready))
    else $error("skid filled without an output stall");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (rst)
    !s_tready |=> $stable(vld)) else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

/* design/erm_reduce.sv */
// Angle reduction modulo pi/2: quadrant, sign and Q30 magnitude of the remainder.
// Four register stages; uses erm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erm_reduce #(
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ANGLE_WIDTH-1:0]  angle,
  output erm_pkg::erm_red_t       red
);
  import erm_pkg::*;

  localparam int SHX = 36 - ANGLE_WIDTH;

  logic signed [36:0] xw;
  logic signed [36:0] x1;
  logic signed [37:0] y1;
  logic [3:0]         cnt_c;
  logic signed [37:0] khp_c;
  logic signed [36:0] x2;
  logic signed [37:0] khp2;
  logic [1:0]         q2;
  logic signed [33:0] r3;
  logic [1:0]         q3;
  logic [33:0]        mag3;

  assign xw = 37'($signed(angle)) <<< SHX;

  always_comb begin
    cnt_c = '0;
    for (int j = -4; j <= 5; j++) begin
      cnt_c = cnt_c + 4'(y1 >= hp_times(j));
    end
    khp_c = '0;
    for (int j = 0; j <= 10; j++) begin
      if (cnt_c == 4'(j)) khp_c = hp_times(j - 5);
    end
  end

  assign mag3 = r3[33] ? 34'(-r3) : 34'(r3);

  always_ff @(posedge clk) begin
    if (en) begin
      x1   <= xw;
      y1   <= 38'(xw) + HALF_PI_HALF;
      x2   <= x1;
      khp2 <= khp_c;
      q2   <= 2'(cnt_c + 4'd3);
      r3   <= 34'(38'(x2) - khp2);
      q3   <= q2;
      red.m   <= mag3[31:2];
      red.neg <= r3[33];
      red.q   <= q3;
    end
  end

endmodule

`default_nettype wire

/* design/erm_poly.sv */
// Sine and cosine series by nested Horner steps, one multiply per stage, plus quadrant map.
// Fourteen register stages; uses erm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erm_poly (
  input  logic               clk,
  input  logic               en,
  input  erm_pkg::erm_red_t  red,
  output erm_pkg::erm_sc_t   sc
);
  import erm_pkg::*;

  localparam int NIT = COS_STEPS;

  // b: after the z*t product stage, a: after the divide-by-constant stage
  logic [29:0] zb  [NIT-1];
  logic [29:0] mb  [NIT-1];
  logic [29:0] za  [NIT-1];
  logic [29:0] ma  [NIT-1];
  logic [29:0] pc  [NIT];
  logic [29:0] ps  [NIT];
  logic [29:0] qc  [NIT];
  logic [29:0] qs  [NIT];
  logic [2:0]  sdb [NIT];
  logic [2:0]  sda [NIT];

  logic [59:0]        zsq;
  logic signed [31:0] s_ext;
  logic signed [31:0] f1_s;
  logic signed [31:0] f1_c;
  logic [1:0]         f1_q;

  assign zsq = 60'(red.m) * 60'(red.m);

  for (genvar i = 0; i < NIT; i++) begin : g_it
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          zb[i]  <= zsq[59:30];
          mb[i]  <= red.m;
          pc[i]  <= zsq[59:30];
          ps[i]  <= zsq[59:30];
          sdb[i] <= {red.neg, red.q};
        end
      end
    end else begin : g_next
      logic [30:0] tc;
      logic [30:0] ts;
      assign tc = Q30_ONE - 31'(qc[i-1]);
      assign ts = Q30_ONE - 31'(qs[i-1]);
      always_ff @(posedge clk) begin
        if (en) begin
          pc[i]  <= 30'((61'(za[i-1]) * 61'(tc)) >> 30);
          sdb[i] <= sda[i-1];
        end
      end
      if (i < SIN_STEPS) begin : g_sin_step
        always_ff @(posedge clk) begin
          if (en) begin
            ps[i] <= 30'((61'(za[i-1]) * 61'(ts)) >> 30);
            zb[i] <= za[i-1];
            mb[i] <= ma[i-1];
          end
        end
      end else begin : g_sin_last
        always_ff @(posedge clk) begin
          if (en) ps[i] <= 30'((61'(ma[i-1]) * 61'(ts)) >> 30);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qc[i]  <= 30'((62'(pc[i]) * 62'(COS_MAGIC[i])) >> COS_SHIFT[i]);
        sda[i] <= sdb[i];
      end
    end
    if (i < SIN_STEPS) begin : g_sin_div
      always_ff @(posedge clk) begin
        if (en) begin
          qs[i] <= 30'((62'(ps[i]) * 62'(SIN_MAGIC[i])) >> SIN_SHIFT[i]);
          za[i] <= zb[i];
          ma[i] <= mb[i];
        end
      end
    end else begin : g_sin_hold
      always_ff @(posedge clk) begin
        if (en) qs[i] <= ps[i];
      end
    end
  end

  assign s_ext = {2'b00, qs[NIT-1]};

  always_ff @(posedge clk) begin
    if (en) begin
      f1_s <= sda[NIT-1][2] ? -s_ext : s_ext;
      f1_c <= {1'b0, Q30_ONE - 31'(qc[NIT-1])};
      f1_q <= sda[NIT-1][1:0];
      case (f1_q)
        2'd0:    begin sc.sn <= f1_s;  sc.cs <= f1_c;  end
        2'd1:    begin sc.sn <= f1_c;  sc.cs <= -f1_s; end
        2'd2:    begin sc.sn <= -f1_s; sc.cs <= -f1_c; end
        default: begin sc.sn <= -f1_c; sc.cs <= f1_s;  end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/erm_matrix.sv */
// Product tree for the nine matrix entries, then rounding and saturation to Q1.(W-2).
// Four register stages; uses erm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module erm_matrix #(
  parameter int ENTRY_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        en,
  input  erm_pkg::erm_sc_t            ax,
  input  erm_pkg::erm_sc_t            ay,
  input  erm_pkg::erm_sc_t            az,
  output logic [9*ENTRY_WIDTH-1:0]    ent
);
  import erm_pkg::*;

  localparam int EF    = ENTRY_WIDTH - 2;
  localparam int SH    = 30 - EF;
  localparam int SH_M1 = (SH > 0) ? SH - 1 : 0;
  localparam logic [32:0] RND = (SH > 0) ? (33'd1 << SH_M1) : 33'd0;
  localparam logic [32:0] LIM = 33'd1 << EF;

  function automatic logic [ENTRY_WIDTH-1:0] to_entry(input logic signed [32:0] v);
    logic [32:0] mag;
    logic [32:0] rm;
    mag = v[32] ? 33'(-v) : 33'(v);
    rm  = (mag + RND) >> SH;
    if (rm > LIM) rm = LIM;
    return v[32] ? ENTRY_WIDTH'(-rm) : ENTRY_WIDTH'(rm);
  endfunction

  logic signed [31:0] sxsz, sycz, cycz, szcx, syx, czcx, sysz, cysx, sycx, szcy, cxcy;
  logic signed [31:0] sx1, sy1, cy1, cz1;
  logic signed [31:0] pa, pb, pc, pd;
  logic signed [31:0] cycz2, sycz2, szcy2, sysz2, szcx2, czcx2, sycx2, cxcy2, sx2;
  logic signed [32:0] sum [9];

  always_ff @(posedge clk) begin
    if (en) begin
      sxsz <= mul_q30(ax.sn, az.sn);
      sycz <= mul_q30(ay.sn, az.cs);
      cycz <= mul_q30(ay.cs, az.cs);
      szcx <= mul_q30(az.sn, ax.cs);
      syx  <= mul_q30(ay.sn, ax.sn);
      czcx <= mul_q30(az.cs, ax.cs);
      sysz <= mul_q30(ay.sn, az.sn);
      cysx <= mul_q30(ay.cs, ax.sn);
      sycx <= mul_q30(ay.sn, ax.cs);
      szcy <= mul_q30(az.sn, ay.cs);
      cxcy <= mul_q30(ax.cs, ay.cs);
      sx1  <= ax.sn;
      sy1  <= ay.sn;
      cy1  <= ay.cs;
      cz1  <= az.cs;

      pa    <= mul_q30(sy1, sxsz);
      pb    <= mul_q30(cy1, sxsz);
      pc    <= mul_q30(syx, cz1);
      pd    <= mul_q30(cysx, cz1);
      cycz2 <= cycz;
      sycz2 <= sycz;
      szcy2 <= szcy;
      sysz2 <= sysz;
      szcx2 <= szcx;
      czcx2 <= czcx;
      sycx2 <= sycx;
      cxcy2 <= cxcy;
      sx2   <= sx1;

      sum[0] <= 33'(cycz2) - 33'(pa);
      sum[1] <= -33'(szcx2);
      sum[2] <= 33'(sycz2) + 33'(pb);
      sum[3] <= 33'(szcy2) + 33'(pc);
      sum[4] <= 33'(czcx2);
      sum[5] <= 33'(sysz2) - 33'(pd);
      sum[6] <= -33'(sycx2);
      sum[7] <= 33'(sx2);
      sum[8] <= 33'(cxcy2);

      for (int e = 0; e < 9; e++) begin
        ent[e*ENTRY_WIDTH +: ENTRY_WIDTH] <= to_entry(sum[e]);
      end
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Testbench for euler_rotation_matrix: drives angle triples on the input stream and
// checks all nine matrix entries of each output word against a fixed-point predictor.
// Depends on the euler_rotation_matrix RTL.
`timescale 1ns / 1ps

class rot_scoreboard;
  logic [143:0] matrix_q[$];
  int errors;

  static function longint mag64(longint v);
    return v < 0 ? -v : v;
  endfunction

  static function longint rmul(longint a, longint b);
    longint r;
    r = (mag64(a) * mag64(b) + (64'sd1 <<< 29)) >>> 30;
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  static function void sin_cos(logic signed [15:0] ang, output longint sn, output longint cs);
    longint hp, x, k, r, s, c, m, z, t;
    longint sd[5];
    longint cd[6];
    sd = '{110, 72, 42, 20, 6};
    cd = '{132, 90, 56, 30, 12, 2};
    hp = 64'h1921FB544;
    x = longint'(ang) * (64'sd1 <<< 20);
    k = (x + hp / 2 + 8 * hp) / hp - 8;
    r = x - k * hp;
    m = mag64(r) >>> 2;
    z = (m * m) >>> 30;
    t = 64'sd1 <<< 30;
    for (int i = 0; i < 5; i++) t = (64'sd1 <<< 30) - ((z * t) >>> 30) / sd[i];
    s = (m * t) >>> 30;
    if (r < 0) s = -s;
    t = 64'sd1 <<< 30;
    for (int i = 0; i < 6; i++) t = (64'sd1 <<< 30) - ((z * t) >>> 30) / cd[i];
    c = t;
    case (k & 3)
      0: begin sn = s; cs = c; end
      1: begin sn = c; cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endfunction

  static function logic [15:0] entry(longint v);
    longint m;
    m = (mag64(v) + (64'sd1 <<< 15)) >>> 16;
    if (m > 16384) m = 16384;
    return 16'(v < 0 ? -m : m);
  endfunction

  function void note_angles(logic [47:0] d);
    longint sx, cx, sy, cy, sz, cz, sxsz, sycz;
    logic [143:0] e;
    sin_cos(d[15:0], sx, cx);
    sin_cos(d[31:16], sy, cy);
    sin_cos(d[47:32], sz, cz);
    sxsz = rmul(sx, sz);
    sycz = rmul(sy, cz);
    e[15:0]    = entry(rmul(cy, cz) - rmul(sy, sxsz));
    e[31:16]   = entry(-rmul(sz, cx));
    e[47:32]   = entry(sycz + rmul(cy, sxsz));
    e[63:48]   = entry(rmul(sz, cy) + rmul(rmul(sy, sx), cz));
    e[79:64]   = entry(rmul(cz, cx));
    e[95:80]   = entry(rmul(sy, sz) - rmul(rmul(cy, sx), cz));
    e[111:96]  = entry(-rmul(sy, cx));
    e[127:112] = entry(sx);
    e[143:128] = entry(rmul(cx, cy));
    matrix_q.push_back(e);
  endfunction

  task report(string msg);
    errors++;
    $display("%s", msg);
  endtask

  task check_matrix(logic [143:0] got);
    logic [143:0] exp;
    if (matrix_q.size() == 0) begin
      report($sformatf("unexpected output word %h", got));
      return;
    end
    exp = matrix_q.pop_front();
    for (int i = 0; i < 9; i++)
      if (got[16*i +: 16] !== exp[16*i +: 16])
        report($sformatf("entry m%0d%0d: got %h exp %h", i / 3, i % 3,
                         got[16*i +: 16], exp[16*i +: 16]));
  endtask
endclass

module tb;
  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [47:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [143:0] m_tdata;
  rot_scoreboard sb = new();
  longint cycles = 0;
  bit drain_stall = 0;

  euler_rotation_matrix u_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: rotates through three stall modes
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_matrix(m_tdata);
    case ((cycles / 300) % 3)
      0: m_tready <= 1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 1) == 0);
    endcase
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 200)) - 16'd100;
      3: return 16'd6434 * 16'($urandom_range(0, 9)) - 16'd32170
                + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_triple(logic [47:0] d);
    s_tvalid <= 1;
    s_tdata <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_angles(d);
  endtask

  task automatic idle(int n);
    s_tvalid <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [15:0] dir[$];
    int burst;
    dir = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'd6434, -16'sd6434,
            16'd12868, 16'd3217, 16'd3216, 16'd19302, 16'd25736};
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir[i]) send_triple({dir[(i + 2) % 12], dir[(i + 1) % 12], dir[i]});
    send_triple({16'd3217, 16'd3217, 16'd3217});
    send_triple({16'h8000, 16'h8000, 16'h8000});
    send_triple({16'h7fff, 16'h7fff, 16'h7fff});
    idle(1);
    while (sb.matrix_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 1300; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++, n++)
        send_triple({rand_angle(), rand_angle(), rand_angle()});
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 8));
    end
    idle(1);
    while (sb.matrix_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
